@@ rtl/core/sfr_pkg.sv @@
// ============================================================================
// sfr_pkg - shared types and constants for the stream find/replace block
// Request layouts, queue entry format, command and register codes, FSM states.
// ============================================================================
package sfr_pkg;

    localparam int MAX_PATTERN_DEF     = 16;
    localparam int MAX_REPLACEMENT_DEF = 64;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam int TALLY_W = 23;
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    localparam int SEARCH_LEN_W  = 5;
    localparam int REPLACE_LEN_W = 7;
    localparam int CFG_DATA_W    = 7;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_LENGTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_LENGTH = 1'd1;

    typedef enum logic [1:0] {
        CMD_LOAD_PATTERN = 2'd0,
        CMD_LOAD_REPLACE = 2'd1,
        CMD_CONTENT      = 2'd2,
        CMD_END          = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  data_byte;
        logic [5:0]  position;
    } in_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               is_count_report;
        logic [TALLY_W-1:0] matches_found;
        logic               last;
    } out_t;

    // work handed from front to back
    typedef enum logic [1:0] {
        ACT_BYTE   = 2'd0,
        ACT_REPL   = 2'd1,
        ACT_REPORT = 2'd2
    } act_kind_t;

    typedef struct packed {
        act_kind_t          kind;
        logic [7:0]         data;
        logic [TALLY_W-1:0] tally;
        logic               last;
    } act_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic {
        F_RUN   = 1'b0,
        F_FLUSH = 1'b1
    } front_state_t;

    typedef enum logic {
        B_IDLE = 1'b0,
        B_RUN  = 1'b1
    } back_state_t;

endpackage

@@ rtl/core/sfr_ram.sv @@
// ============================================================================
// sfr_ram - generic single write, single read RAM
// One write port, one read port with registered read data.
// ============================================================================
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/sfr_queue.sv @@
// ============================================================================
// sfr_queue - short action queue between front and back
// Register FIFO of action entries; pop data shown from the head.
// ============================================================================
module sfr_queue #(
    parameter int DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sfr_pkg::act_t      push_data,
    input  logic               pop,
    output sfr_pkg::act_t      pop_data,
    output sfr_pkg::q_status_t status
);

    import sfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    act_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));

endmodule

@@ rtl/core/sfr_front.sv @@
// ============================================================================
// sfr_front - request intake, window and pattern compare
// Loads the stores, keeps the match window and tally, queues output actions.
// ============================================================================
module sfr_front #(
    parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF,
    localparam int PW  = $clog2(MAX_PATTERN + 1),
    localparam int RAW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sfr_pkg::in_t       in_data,
    input  logic [PW-1:0]      plen,
    input  logic               rlen_zero,
    input  sfr_pkg::q_status_t q_status,
    input  logic               drained,
    output logic               push,
    output sfr_pkg::act_t      push_data,
    output logic               ram_we,
    output logic [RAW-1:0]     ram_waddr,
    output logic [7:0]         ram_wdata
);

    import sfr_pkg::*;

    localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    front_state_t       state_reg, state_next;
    logic [PW-1:0]      fill_reg, fill_next;
    logic [PW-1:0]      flush_idx_reg, flush_idx_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic [7:0]         win_reg  [MAX_PATTERN];
    logic [7:0]         win_next [MAX_PATTERN];
    logic [7:0]         pat_reg  [MAX_PATTERN];

    logic               accept;
    logic               is_content;
    logic               is_end;
    logic [PW-1:0]      fill_app;
    logic [7:0]         win_app [MAX_PATTERN];
    logic               win_full;
    logic               hit;
    logic [PW-1:0]      shift;
    logic [PW:0]        src;
    logic [TALLY_W-1:0] tally_inc;
    logic               flush_more;
    logic               pat_we;

    assign accept     = in_valid && in_ready;
    assign is_content = (in_data.command == CMD_CONTENT);
    assign is_end     = (in_data.command == CMD_END);
    assign flush_more = (flush_idx_reg < fill_reg);

    // window with the new byte appended, then compared and shifted
    always_comb
    begin
        fill_app = (fill_reg < PW'(MAX_PATTERN)) ? fill_reg + PW'(1) : fill_reg;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_app[i] = (PW'(i) == fill_reg) ? in_data.data_byte : win_reg[i];
        end
        win_full = (fill_app >= plen);
        hit      = win_full;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((PW'(i) < plen) && (win_app[i] != pat_reg[i]))
            begin
                hit = 1'b0;
            end
        end
        tally_inc = (tally_reg != TALLY_MAX) ? tally_reg + TALLY_W'(1) : tally_reg;
        shift     = hit ? plen : PW'(1);
    end

    // front FSM: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_RUN:
            begin
                if (accept && is_end && (fill_reg != '0))
                begin
                    state_next = F_FLUSH;
                end
            end
            F_FLUSH:
            begin
                if (!q_status.full && !flush_more)
                begin
                    state_next = F_RUN;
                end
            end
            default: state_next = F_RUN;
        endcase
    end

    // front FSM: outputs
    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        unique case (state_reg)
            F_RUN:
            begin
                // replacement loads wait until no run can read the store
                in_ready = !q_status.full &&
                           ((in_data.command != CMD_LOAD_REPLACE) || drained);
                push     = accept &&
                           ((is_content && win_full && !(hit && rlen_zero)) ||
                            (is_end && (fill_reg == '0)));
            end
            F_FLUSH:
            begin
                push = !q_status.full;
            end
            default:
            begin
                in_ready = 1'b0;
                push     = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        fill_next      = fill_reg;
        flush_idx_next = flush_idx_reg;
        tally_next     = tally_reg;
        win_next       = win_reg;
        src            = '0;
        push_data.kind  = ACT_BYTE;
        push_data.data  = win_app[0];
        push_data.tally = tally_reg;
        push_data.last  = 1'b1;

        if (state_reg == F_FLUSH)
        begin
            if (flush_more)
            begin
                push_data.data = win_reg[flush_idx_reg[PAW-1:0]];
                push_data.last = 1'b0;
                if (!q_status.full)
                begin
                    flush_idx_next = flush_idx_reg + PW'(1);
                end
            end
            else
            begin
                push_data.kind = ACT_REPORT;
                push_data.data = '0;
                if (!q_status.full)
                begin
                    fill_next  = '0;
                    tally_next = '0;
                end
            end
        end
        else if (accept && is_content)
        begin
            if (win_full)
            begin
                if (hit)
                begin
                    push_data.kind  = ACT_REPL;
                    push_data.tally = tally_inc;
                    tally_next      = tally_inc;
                end
                for (int i = 0; i < MAX_PATTERN; i++)
                begin
                    src = (PW + 1)'(i) + {1'b0, shift};
                    if (src < (PW + 1)'(MAX_PATTERN))
                    begin
                        win_next[i] = win_app[src[PAW-1:0]];
                    end
                    else
                    begin
                        win_next[i] = win_app[i];
                    end
                end
                fill_next = fill_app - shift;
            end
            else
            begin
                win_next  = win_app;
                fill_next = fill_app;
            end
        end
        else if (accept && is_end)
        begin
            flush_idx_next = '0;
            if (fill_reg == '0)
            begin
                push_data.kind = ACT_REPORT;
                push_data.data = '0;
                tally_next     = '0;
            end
        end
    end

    assign pat_we    = accept && (in_data.command == CMD_LOAD_PATTERN) &&
                       (32'(in_data.position) < MAX_PATTERN);
    assign ram_we    = accept && (in_data.command == CMD_LOAD_REPLACE) &&
                       (32'(in_data.position) < MAX_REPLACEMENT);
    assign ram_waddr = in_data.position[RAW-1:0];
    assign ram_wdata = in_data.data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_RUN;
            fill_reg      <= '0;
            flush_idx_reg <= '0;
            tally_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            flush_idx_reg <= flush_idx_next;
            tally_reg     <= tally_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (pat_we)
        begin
            pat_reg[in_data.position[PAW-1:0]] <= in_data.data_byte;
        end
    end

endmodule

@@ rtl/core/sfr_back.sv @@
// ============================================================================
// sfr_back - action execution and output register
// Emits queued bytes and reports, and streams replacement runs from the RAM.
// ============================================================================
module sfr_back #(
    parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF,
    localparam int RW  = $clog2(MAX_REPLACEMENT + 1),
    localparam int RAW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sfr_pkg::q_status_t q_status,
    output logic               pop,
    input  sfr_pkg::act_t      pop_data,
    input  logic [RW-1:0]      rlen,
    output logic [RAW-1:0]     ram_raddr,
    input  logic [7:0]         ram_rdata,
    output logic               idle,
    output logic               out_valid,
    input  logic               out_ready,
    output sfr_pkg::out_t      out_data
);

    import sfr_pkg::*;

    back_state_t        state_reg, state_next;
    logic [RAW-1:0]     idx_reg, idx_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_data_reg, out_data_next;

    logic               space;
    logic               run_last;
    logic               load;

    assign space    = !out_valid_reg || out_ready;
    assign run_last = ((RW'(idx_reg) + RW'(1)) == rlen);

    // back FSM: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop && (pop_data.kind == ACT_REPL))
                begin
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (space && run_last)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // back FSM: outputs
    always_comb
    begin
        pop  = 1'b0;
        load = 1'b0;
        idle = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                idle = 1'b1;
                pop  = !q_status.empty && space;
                load = pop && (pop_data.kind != ACT_REPL);
            end
            B_RUN:
            begin
                load = space;
            end
            default:
            begin
                idle = 1'b1;
            end
        endcase
    end

    // datapath; RAM address runs one ahead so read data meets idx_reg
    always_comb
    begin
        idx_next       = idx_reg;
        tally_next     = tally_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (state_reg == B_RUN)
        begin
            if (space)
            begin
                idx_next                      = idx_reg + RAW'(1);
                out_data_next.out_byte        = ram_rdata;
                out_data_next.is_count_report = 1'b0;
                out_data_next.matches_found   = tally_reg;
                out_data_next.last            = run_last;
            end
        end
        else if (pop)
        begin
            idx_next   = '0;
            tally_next = pop_data.tally;
            if (pop_data.kind != ACT_REPL)
            begin
                out_data_next.out_byte        = pop_data.data;
                out_data_next.is_count_report = (pop_data.kind == ACT_REPORT);
                out_data_next.matches_found   = pop_data.tally;
                out_data_next.last            = pop_data.last;
            end
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign ram_raddr = idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tally_reg    <= tally_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/core/stream_find_replace_top.sv @@
// ============================================================================
// stream_find_replace_top - streaming non-overlapping find and replace
// Pattern and replacement are loaded by request; content bytes pass through
// with every leftmost match swapped for the replacement string.
// ============================================================================
// Path: an accepted request pushes an action into the queue; the back end
//   pops it into the output register, reading replacement runs from the RAM.
// Throughput: one content byte per cycle while the queue is not full; a
//   match with r replacement bytes keeps the back end busy (one read from
//   the replacement RAM per byte), end of content queues the window bytes
//   and a report; replacement loads wait for an empty queue and back end.
// Reset: rst_n asynchronous, active low; clears window fill, match count,
//   queue, both FSMs and the output valid; search_length = 1,
//   replace_length = 0. Pattern and replacement stores are not cleared.
// ============================================================================
module stream_find_replace_top #(
    parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF,
    parameter int QUEUE_DEPTH     = sfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  sfr_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output sfr_pkg::out_t                    out_data,
    input  logic                             cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import sfr_pkg::*;

    localparam int PW  = $clog2(MAX_PATTERN + 1);
    localparam int RW  = $clog2(MAX_REPLACEMENT + 1);
    localparam int RAW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

    // configuration registers
    logic [SEARCH_LEN_W-1:0]  search_length_reg;
    logic [REPLACE_LEN_W-1:0] replace_length_reg;

    // lengths in use after clamping
    logic [PW-1:0] plen;
    logic [RW-1:0] rlen;

    // front to queue to back
    logic       push, pop;
    act_t       push_data, pop_data;
    q_status_t  q_status;
    logic       back_idle;
    logic       drained;

    // replacement RAM ports
    logic           ram_we;
    logic [RAW-1:0] ram_waddr;
    logic [7:0]     ram_wdata;
    logic [RAW-1:0] ram_raddr;
    logic [7:0]     ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_length_reg  <= SEARCH_LEN_W'(1);
            replace_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEARCH_LENGTH:  search_length_reg  <= cfg_data[SEARCH_LEN_W-1:0];
                CFG_REPLACE_LENGTH: replace_length_reg <= cfg_data[REPLACE_LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // zero pattern length acts as one; oversize lengths clamp to the store size
    always_comb
    begin
        if (search_length_reg == '0)
        begin
            plen = PW'(1);
        end
        else if (32'(search_length_reg) > MAX_PATTERN)
        begin
            plen = PW'(MAX_PATTERN);
        end
        else
        begin
            plen = PW'(search_length_reg);
        end
        if (32'(replace_length_reg) > MAX_REPLACEMENT)
        begin
            rlen = RW'(MAX_REPLACEMENT);
        end
        else
        begin
            rlen = RW'(replace_length_reg);
        end
    end

    // nothing queued or running that could read the replacement store
    assign drained = q_status.empty && back_idle;

    sfr_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .plen      (plen),
        .rlen_zero (rlen == '0),
        .q_status  (q_status),
        .drained   (drained),
        .push      (push),
        .push_data (push_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_REPLACEMENT)
    ) u_repl_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sfr_back #(
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop       (pop),
        .pop_data  (pop_data),
        .rlen      (rlen),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .idle      (back_idle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ sim/tb_stream_find_replace_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_stream_find_replace_top - self-checking bench for stream find/replace
// Drives load, content and end-of-content requests through the valid/ready
// input, predicts every output byte and count report with a shadow of the
// matching window, and checks the output stream field by field. Runs a short
// directed sequence, then random phases with varied lengths and idling.
// ============================================================================
module tb_stream_find_replace_top;

    import sfr_pkg::*;

    localparam int MAX_PAT        = MAX_PATTERN_DEF;
    localparam int MAX_REP        = MAX_REPLACEMENT_DEF;
    localparam int RANDOM_ITEMS   = 60;    // content/end requests in the random part
    localparam int MIN_PHASES     = 4;     // one phase of each idling mode at least
    localparam int DRAIN_CYCLES   = 8;     // quiet margin for results still in flight
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
    localparam int PRINT_LIMIT    = 50;

    // How both sides pause during a phase
    typedef enum logic [1:0] {
        IDLE_NONE     = 2'd0,
        IDLE_SENDER   = 2'd1,
        IDLE_RECEIVER = 2'd2,
        IDLE_BOTH     = 2'd3
    } idle_mode_t;

    typedef enum logic [1:0] {
        STEP_REQUEST = 2'd0,
        STEP_SETTING = 2'd1,
        STEP_IDLING  = 2'd2
    } step_kind_t;

    typedef struct {
        step_kind_t              kind;
        in_t                     req;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0]   reg_value;
        idle_mode_t              mode;
    } stim_step_t;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    in_t                     in_data   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    out_t                    out_data;
    logic                    cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    stream_find_replace_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    stim_step_t  stim_queue[$];        // pending requests, settings, idling changes
    out_t        pending_out[$];       // predicted results not yet seen
    idle_mode_t  idle_mode = IDLE_NONE;
    int          quiet_cycles = 0;     // cycles with nothing in flight or expected
    int          stuck_cycles = 0;     // cycles with no handshake of any kind
    int          error_count  = 0;

    // Shadow of the block: stores, window, tally and the two registers
    logic [7:0]               shadow_pattern [MAX_PAT];
    logic [7:0]               shadow_replace [MAX_REP];
    logic [7:0]               shadow_window  [MAX_PAT];
    int                       shadow_fill;
    logic [TALLY_W-1:0]       shadow_tally;
    logic [SEARCH_LEN_W-1:0]  shadow_search_reg;
    logic [REPLACE_LEN_W-1:0] shadow_replace_reg;

    // Generator's view, so that content is built from the pattern in use and
    // no unwritten store entry is ever read
    logic [7:0]  gen_pattern [MAX_PAT];
    bit          pat_loaded  [MAX_PAT];
    bit          rep_loaded  [MAX_REP];
    int          gen_plen     = 1;
    int          gen_rlen     = 0;
    int          stream_items = 0;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    // Length registers clamp: a zero search length acts as one, oversize acts as the maximum
    function automatic int search_in_use(input logic [SEARCH_LEN_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_PAT)
            return MAX_PAT;
        return int'(v);
    endfunction

    function automatic int replace_in_use(input logic [REPLACE_LEN_W-1:0] v);
        if (v > MAX_REP)
            return MAX_REP;
        return int'(v);
    endfunction

    // Bias towards a small alphabet so that matches and near misses are common
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) < 70)
        begin
            case ($urandom_range(3))
                0:       return 8'h00;
                1:       return 8'h01;
                2:       return 8'h80;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Shadow of the matcher
    // ------------------------------------------------------------------------
    task automatic drop_oldest(input int n);
        if (n >= shadow_fill)
        begin
            shadow_fill = 0;
            return;
        end
        for (int i = 0; i + n < shadow_fill; i++)
            shadow_window[i] = shadow_window[i + n];
        shadow_fill -= n;
    endtask

    // Works out the results one accepted request causes and queues them
    task automatic apply_find_replace(input in_t req);
        out_t batch[$];
        out_t res;
        int   plen;
        int   rlen;
        bit   hit;

        plen = search_in_use(shadow_search_reg);
        rlen = replace_in_use(shadow_replace_reg);
        res  = '0;

        case (req.command)
            CMD_LOAD_PATTERN:
            begin
                if (req.position < MAX_PAT)
                    shadow_pattern[req.position] = req.data_byte;
            end
            CMD_LOAD_REPLACE:
            begin
                if (req.position < MAX_REP)
                    shadow_replace[req.position] = req.data_byte;
            end
            CMD_CONTENT:
            begin
                if (shadow_fill < MAX_PAT)
                begin
                    shadow_window[shadow_fill] = req.data_byte;
                    shadow_fill++;
                end
                // window full: compare its oldest plen bytes with the pattern
                if (shadow_fill >= plen)
                begin
                    hit = 1'b1;
                    for (int i = 0; i < plen; i++)
                        if (shadow_window[i] != shadow_pattern[i])
                            hit = 1'b0;
                    if (hit)
                    begin
                        if (shadow_tally != TALLY_MAX)
                            shadow_tally++;
                        for (int i = 0; i < rlen; i++)
                        begin
                            res.out_byte      = shadow_replace[i];
                            res.matches_found = shadow_tally;
                            batch.push_back(res);
                        end
                        drop_oldest(plen);
                    end
                    else
                    begin
                        res.out_byte      = shadow_window[0];
                        res.matches_found = shadow_tally;
                        batch.push_back(res);
                        drop_oldest(1);
                    end
                end
            end
            default:
            begin
                // end of content: flush the window, then report and clear the tally
                for (int i = 0; i < shadow_fill; i++)
                begin
                    res.out_byte      = shadow_window[i];
                    res.matches_found = shadow_tally;
                    batch.push_back(res);
                end
                res.out_byte        = 8'h00;
                res.is_count_report = 1'b1;
                res.matches_found   = shadow_tally;
                batch.push_back(res);
                shadow_fill  = 0;
                shadow_tally = '0;
            end
        endcase

        if (batch.size() != 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            pending_out.push_back(batch[i]);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic push_request(input cmd_t cmd, input logic [7:0] b, input logic [5:0] pos);
        stim_step_t s;
        s.kind           = STEP_REQUEST;
        s.req.command    = cmd;
        s.req.data_byte  = b;
        s.req.position   = pos;
        s.reg_index      = '0;
        s.reg_value      = '0;
        s.mode           = IDLE_NONE;
        stim_queue.push_back(s);
        if (cmd == CMD_LOAD_PATTERN && pos < MAX_PAT)
        begin
            gen_pattern[pos] = b;
            pat_loaded[pos]  = 1'b1;
        end
        if (cmd == CMD_LOAD_REPLACE && pos < MAX_REP)
            rep_loaded[pos] = 1'b1;
        if (cmd == CMD_CONTENT || cmd == CMD_END)
            stream_items++;
    endtask

    task automatic push_content(input logic [7:0] b);
        push_request(CMD_CONTENT, b, 6'($urandom_range(63)));
    endtask

    // A register write; any store entry the new lengths use gets loaded after it, before later content
    task automatic push_setting(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        stim_step_t s;
        s.kind      = STEP_SETTING;
        s.req       = '0;
        s.reg_index = idx;
        s.reg_value = val;
        s.mode      = IDLE_NONE;
        stim_queue.push_back(s);
        if (idx == CFG_SEARCH_LENGTH)
            gen_plen = search_in_use(val[SEARCH_LEN_W-1:0]);
        else
            gen_rlen = replace_in_use(val[REPLACE_LEN_W-1:0]);
        for (int i = 0; i < gen_plen; i++)
            if (!pat_loaded[i])
                push_request(CMD_LOAD_PATTERN, pick_byte(), 6'(i));
        for (int i = 0; i < gen_rlen; i++)
            if (!rep_loaded[i])
                push_request(CMD_LOAD_REPLACE, 8'($urandom), 6'(i));
    endtask

    task automatic push_idling(input idle_mode_t m);
        stim_step_t s;
        s.kind      = STEP_IDLING;
        s.req       = '0;
        s.reg_index = '0;
        s.reg_value = '0;
        s.mode      = m;
        stim_queue.push_back(s);
    endtask

    // Mostly whole copies of the pattern, with truncated copies, loose bytes
    // and the odd stray load mixed in
    task automatic push_content_run(input int n);
        int made;
        int cut;
        int r;
        made = 0;
        while (made < n)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                for (int i = 0; i < gen_plen; i++)
                    push_content(gen_pattern[i]);
                made += gen_plen;
            end
            else if (r < 65)
            begin
                cut = $urandom_range(1, gen_plen);
                for (int i = 0; i < cut; i++)
                    push_content(gen_pattern[i]);
                made += cut;
            end
            else if (r < 93)
            begin
                push_content(pick_byte());
                made++;
            end
            else if ($urandom_range(1) == 0)
                push_request(CMD_LOAD_PATTERN, pick_byte(), 6'($urandom_range(63)));
            else
                push_request(CMD_LOAD_REPLACE, 8'($urandom), 6'($urandom_range(63)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Request driver: takes the next step from stim_queue. Register writes
    // wait until nothing is in flight and the pipeline has had time to empty.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        logic                    nxt_valid;
        logic                    nxt_we;
        in_t                     nxt_req;
        logic [CFG_INDEX_W-1:0]  nxt_index;
        logic [CFG_DATA_W-1:0]   nxt_value;
        int                      gap_pct;

        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            // keep a request up until it is taken
            nxt_valid = in_valid && !in_ready;
            nxt_req   = in_data;
            nxt_we    = 1'b0;
            nxt_index = cfg_index;
            nxt_value = cfg_data;
            gap_pct   = (idle_mode == IDLE_SENDER) ? 52 :
                        (idle_mode == IDLE_BOTH)   ? 7  : 0;

            if (!nxt_valid && stim_queue.size() != 0)
            begin
                case (stim_queue[0].kind)
                    STEP_REQUEST:
                    begin
                        if ($urandom_range(99) >= gap_pct)
                        begin
                            nxt_valid = 1'b1;
                            nxt_req   = stim_queue[0].req;
                            void'(stim_queue.pop_front());
                        end
                    end
                    STEP_SETTING:
                    begin
                        // no request taken this edge and the block long quiet
                        if (!in_valid && quiet_cycles >= DRAIN_CYCLES)
                        begin
                            nxt_we    = 1'b1;
                            nxt_index = stim_queue[0].reg_index;
                            nxt_value = stim_queue[0].reg_value;
                            void'(stim_queue.pop_front());
                        end
                    end
                    default:
                    begin
                        idle_mode <= stim_queue[0].mode;
                        void'(stim_queue.pop_front());
                    end
                endcase
            end

            in_valid  <= nxt_valid;
            in_data   <= nxt_req;
            cfg_we    <= nxt_we;
            cfg_index <= nxt_index;
            cfg_data  <= nxt_value;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each taken result against the oldest prediction, feeds
    // taken requests and register writes to the shadow, drives out_ready and
    // watches for a hang.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        out_t want;
        int   stall_pct;
        bit   busy;

        if (!rst_n)
        begin
            out_ready          <= 1'b0;
            quiet_cycles       <= 0;
            stuck_cycles       <= 0;
            shadow_fill        = 0;
            shadow_tally       = '0;
            shadow_search_reg  = SEARCH_LEN_W'(1);
            shadow_replace_reg = '0;
            foreach (shadow_window[i])
                shadow_window[i] = 8'h00;
            foreach (shadow_pattern[i])
                shadow_pattern[i] = 8'h00;
            foreach (shadow_replace[i])
                shadow_replace[i] = 8'h00;
        end
        else
        begin
            // check before predicting: a result never belongs to a request
            // taken at the same edge
            if (out_valid && out_ready)
            begin
                if (pending_out.size() == 0)
                    report_mismatch($sformatf("unexpected result, byte %02h report %0b",
                                              out_data.out_byte, out_data.is_count_report));
                else
                begin
                    want = pending_out.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                                                  out_data.out_byte, want.out_byte));
                    if (out_data.is_count_report !== want.is_count_report)
                        report_mismatch($sformatf("is_count_report got %0b want %0b",
                                                  out_data.is_count_report,
                                                  want.is_count_report));
                    if (out_data.matches_found !== want.matches_found)
                        report_mismatch($sformatf("matches_found got %0d want %0d",
                                                  out_data.matches_found,
                                                  want.matches_found));
                    if (out_data.last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  out_data.last, want.last));
                end
            end

            if (in_valid && in_ready)
                apply_find_replace(in_data);

            // the block sees the write at the edge after cfg_we goes high
            if (cfg_we)
            begin
                if (cfg_index == CFG_SEARCH_LENGTH)
                    shadow_search_reg = cfg_data[SEARCH_LEN_W-1:0];
                else if (cfg_index == CFG_REPLACE_LENGTH)
                    shadow_replace_reg = cfg_data[REPLACE_LEN_W-1:0];
            end

            busy = (in_valid && in_ready) || (out_valid && out_ready) ||
                   (pending_out.size() != 0);
            if (busy)
                quiet_cycles <= 0;
            else if (quiet_cycles < WATCHDOG_LIMIT)
                quiet_cycles <= quiet_cycles + 1;

            stall_pct = (idle_mode == IDLE_RECEIVER) ? 52 :
                        (idle_mode == IDLE_BOTH)     ? 7  : 0;
            out_ready <= ($urandom_range(99) >= stall_pct);

            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;

            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin : run_control
        int directed_items;
        int phase;

        foreach (pat_loaded[i])
            pat_loaded[i] = 1'b0;
        foreach (rep_loaded[i])
            rep_loaded[i] = 1'b0;
        foreach (gen_pattern[i])
            gen_pattern[i] = 8'h00;

        // --- directed part ---
        push_idling(IDLE_NONE);
        // pattern 00 FF 00; a pattern load beyond the store is dropped
        push_request(CMD_LOAD_PATTERN, 8'h00, 6'd0);
        push_request(CMD_LOAD_PATTERN, 8'hFF, 6'd1);
        push_request(CMD_LOAD_PATTERN, 8'h00, 6'd2);
        push_request(CMD_LOAD_PATTERN, 8'hA5, 6'd63);
        push_request(CMD_LOAD_REPLACE, 8'hFF, 6'd0);
        push_request(CMD_LOAD_REPLACE, 8'h00, 6'd1);
        push_request(CMD_LOAD_REPLACE, 8'h5A, 6'd63);
        push_setting(CFG_SEARCH_LENGTH, 7'd3);
        push_setting(CFG_REPLACE_LENGTH, 7'd2);
        // plain match, then a near miss, then overlapping candidates where
        // only the leftmost may be taken
        push_content(8'h00);
        push_content(8'hFF);
        push_content(8'h00);
        push_content(8'h00);
        push_content(8'hFF);
        push_content(8'hFF);
        push_content(8'h00);
        push_content(8'hFF);
        push_content(8'h00);
        push_content(8'hFF);
        push_content(8'h00);
        // flush a part-filled window, then report on an empty one
        push_request(CMD_END, 8'hFF, 6'd63);
        push_request(CMD_END, 8'h00, 6'd0);
        // leave four bytes in a five-byte window, then shrink the pattern to
        // two bytes with deletion: the oldest bytes match, the rest drain
        push_setting(CFG_SEARCH_LENGTH, 7'd5);
        push_content(8'h00);
        push_content(8'hFF);
        push_content(8'h00);
        push_content(8'h01);
        push_setting(CFG_SEARCH_LENGTH, 7'd2);
        push_setting(CFG_REPLACE_LENGTH, 7'd0);
        push_content(8'h5A);
        push_content(8'hFF);
        push_content(8'h00);
        push_content(8'hFF);
        push_request(CMD_END, 8'h5A, 6'd21);
        directed_items = stream_items;

        // --- random phases ---
        // the first three force the register extremes, including the
        // out-of-range values that clamp
        phase = 0;
        while (phase < MIN_PHASES || stream_items < directed_items + RANDOM_ITEMS)
        begin
            push_idling(idle_mode_t'(phase % 4));
            case (phase)
                0:
                begin
                    push_setting(CFG_SEARCH_LENGTH, 7'd16);
                    push_setting(CFG_REPLACE_LENGTH, 7'd64);
                end
                1:
                begin
                    push_setting(CFG_SEARCH_LENGTH, 7'd0);
                    push_setting(CFG_REPLACE_LENGTH, 7'd1);
                end
                2:
                begin
                    push_setting(CFG_SEARCH_LENGTH, 7'h7F);
                    push_setting(CFG_REPLACE_LENGTH, 7'd127);
                end
                default:
                begin
                    // a write to one register only keeps the window across
                    // the change of length
                    if ($urandom_range(99) < 70)
                    begin
                        case ($urandom_range(19))
                            0:       push_setting(CFG_SEARCH_LENGTH, 7'd0);
                            1:       push_setting(CFG_SEARCH_LENGTH, 7'd16);
                            2:       push_setting(CFG_SEARCH_LENGTH, 7'($urandom_range(127)));
                            default: push_setting(CFG_SEARCH_LENGTH, 7'($urandom_range(1, 4)));
                        endcase
                    end
                    if ($urandom_range(99) < 70)
                    begin
                        case ($urandom_range(19))
                            0, 1, 2: push_setting(CFG_REPLACE_LENGTH, 7'd0);
                            3:       push_setting(CFG_REPLACE_LENGTH, 7'd64);
                            4:       push_setting(CFG_REPLACE_LENGTH, 7'($urandom_range(65, 127)));
                            default: push_setting(CFG_REPLACE_LENGTH, 7'($urandom_range(1, 6)));
                        endcase
                    end
                end
            endcase
            if ($urandom_range(99) < 40)
                for (int i = 0; i < gen_plen; i++)
                    push_request(CMD_LOAD_PATTERN, pick_byte(), 6'(i));
            push_content_run($urandom_range(8, 30));
            if ($urandom_range(99) < 65)
                push_request(CMD_END, 8'($urandom), 6'($urandom_range(63)));
            phase++;
        end

        // --- reset, then let the driver and monitor run ---
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // sampled on the falling edge, so every update of the rising edge
        // has settled; the watchdog bounds this wait
        do
            @(negedge clk);
        while (stim_queue.size() != 0 || in_valid || quiet_cycles < DRAIN_CYCLES);

        if (pending_out.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      pending_out.size()));

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
